FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/vtis_pkg.sv
// types and constants for the vlan tag insert / strip block
// no dependencies
package vtis_pkg;

    localparam int MAX_RESULTS = 6;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int POS_W       = 5;

    localparam logic [POS_W-1:0] POS_START     = 5'd0;
    localparam logic [POS_W-1:0] POS_TYPE_HIGH = 5'd12;
    localparam logic [POS_W-1:0] POS_TYPE_LOW  = 5'd13;
    localparam logic [POS_W-1:0] POS_TAG_HIGH  = 5'd14;
    localparam logic [POS_W-1:0] POS_TAG_LOW   = 5'd15;
    localparam logic [POS_W-1:0] POS_SAT       = 5'd16;

    localparam logic [7:0]  TPID_HIGH    = 8'h81;
    localparam logic [7:0]  TPID_LOW     = 8'h00;
    localparam logic [15:0] PCP_DEI_MASK = 16'hf000;
    localparam logic [15:0] VID_MASK     = 16'h0fff;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [11:0] vlan_id;
        logic        mode;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       runt;
    } out_item_t;

    typedef logic [7:0] byte_t;

    // results caused by one input item
    typedef struct packed {
        byte_t [MAX_RESULTS-1:0] bytes;
        logic  [CNT_W-1:0]       count;
        logic                    last;
        logic                    runt;
    } burst_t;

endpackage

FILE: hw/rtl/vtis_edit.sv
// per-frame tag state and the edit of one input item into its result bytes
// depends on vtis_pkg and assert_macros.svh
`include "assert_macros.svh"

module vtis_edit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  vtis_pkg::in_item_t item,
    output vtis_pkg::burst_t   burst
);
    import vtis_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       held_reg, held_next;
    logic             tagged_reg, tagged_next;
    logic [11:0]      vlan_reg, vlan_next;
    logic             mode_reg, mode_next;

    logic [11:0]      vlan_cur;
    logic             mode_cur;
    logic             tagged_cur;
    logic             is_tpid;
    logic [7:0]       pcp_dei;

    always_comb
    begin
        if (pos_reg == POS_START)
        begin
            vlan_cur   = item.vlan_id & VID_MASK[11:0];
            mode_cur   = item.mode;
            tagged_cur = 1'b0;
        end
        else
        begin
            vlan_cur   = vlan_reg;
            mode_cur   = mode_reg;
            tagged_cur = tagged_reg;
        end

        is_tpid = (held_reg == TPID_HIGH) && (item.data_byte == TPID_LOW);
        pcp_dei = item.data_byte & PCP_DEI_MASK[15:8];

        burst       = '0;
        held_next   = held_reg;
        tagged_next = tagged_cur;

        if (pos_reg < POS_TYPE_HIGH)
        begin
            burst.bytes[0] = item.data_byte;
            burst.count    = CNT_W'(1);
        end
        else if (pos_reg == POS_TYPE_HIGH)
        begin
            held_next = item.data_byte;
            if (item.last_byte)
            begin
                burst.bytes[0] = item.data_byte;
                burst.count    = CNT_W'(1);
            end
        end
        else if (pos_reg == POS_TYPE_LOW)
        begin
            tagged_next = is_tpid;
            if (!mode_cur && !is_tpid)
            begin
                burst.bytes[0] = TPID_HIGH;
                burst.bytes[1] = TPID_LOW;
                burst.bytes[2] = {4'h0, vlan_cur[11:8]};
                burst.bytes[3] = vlan_cur[7:0];
                burst.bytes[4] = held_reg;
                burst.bytes[5] = item.data_byte;
                burst.count    = CNT_W'(6);
            end
            else if (!mode_cur || !is_tpid)
            begin
                burst.bytes[0] = held_reg;
                burst.bytes[1] = item.data_byte;
                burst.count    = CNT_W'(2);
            end
        end
        else if (pos_reg inside {POS_TAG_HIGH, POS_TAG_LOW})
        begin
            if (!tagged_cur)
            begin
                burst.bytes[0] = item.data_byte;
                burst.count    = CNT_W'(1);
            end
            else if (!mode_cur)
            begin
                burst.bytes[0] = (pos_reg == POS_TAG_HIGH) ? (pcp_dei | {4'h0, vlan_cur[11:8]})
                                                           : vlan_cur[7:0];
                burst.count    = CNT_W'(1);
            end
        end
        else
        begin
            burst.bytes[0] = item.data_byte;
            burst.count    = CNT_W'(1);
        end

        if (item.last_byte)
        begin
            if (burst.count == '0)
            begin
                burst.bytes[0] = item.data_byte;
                burst.count    = CNT_W'(1);
                burst.runt     = 1'b1;
            end
            burst.last = 1'b1;
            pos_next   = POS_START;
        end
        else if (pos_reg < POS_SAT)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end

        vlan_next = vlan_cur;
        mode_next = mode_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_START;
            held_reg   <= '0;
            tagged_reg <= 1'b0;
            vlan_reg   <= '0;
            mode_reg   <= 1'b0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            held_reg   <= held_next;
            tagged_reg <= tagged_next;
            vlan_reg   <= vlan_next;
            mode_reg   <= mode_next;
        end
    end

    `ASSERT_ALWAYS(a_pos_range, clk, rst_n, pos_reg <= POS_SAT)
    `ASSERT_IMPLIES(a_runt_single, clk, rst_n, burst.runt, burst.count == CNT_W'(1) && burst.last)
    `ASSERT_NEXT(a_last_restarts, clk, rst_n, step && item.last_byte, pos_reg == POS_START)

endmodule

FILE: hw/rtl/vlan_tag_insert_strip.sv
// top level: input register, tag edit, result shift buffer
// depends on vtis_pkg, vtis_edit and assert_macros.svh
// data path: an accepted item waits in the input register until the buffer can take its results
// throughput: one item per cycle while out_ready is high; byte 13 of an untagged frame in add mode
//   expands to six results and holds the input until five have been taken, byte 13
//   of a tagged add or untagged strip frame gives two and holds it until one is taken
// reset: asynchronous, clears buffers and returns to the start of a frame
`include "assert_macros.svh"

module vlan_tag_insert_strip (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vtis_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vtis_pkg::out_item_t out_data
);
    import vtis_pkg::*;

    in_item_t          item_reg;
    logic              item_valid_reg;

    byte_t             buf_reg [MAX_RESULTS];
    byte_t             buf_next [MAX_RESULTS];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic              runt_reg, runt_next;

    burst_t            burst;
    logic              take;
    logic              free;
    logic              load;

    assign take      = out_valid && out_ready;
    assign free      = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && out_ready);
    assign load      = item_valid_reg && free;
    assign in_ready  = !item_valid_reg || load;
    assign out_valid = (cnt_reg != '0);

    assign out_data.out_byte = buf_reg[0];
    assign out_data.out_last = (cnt_reg == CNT_W'(1)) && last_reg;
    assign out_data.runt     = runt_reg;

    vtis_edit u_edit (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (load),
        .item  (item_reg),
        .burst (burst)
    );

    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        runt_next = runt_reg;
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                buf_next[i] = burst.bytes[i];
            end
            cnt_next  = burst.count;
            last_next = burst.last;
            runt_next = burst.runt;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                buf_next[i] = buf_reg[i + 1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
            runt_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
            runt_reg <= runt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        buf_reg <= buf_next;
    end

    `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_reg <= CNT_W'(MAX_RESULTS))
    `ASSERT_IMPLIES(a_runt_is_last, clk, rst_n, out_valid && out_data.runt, out_data.out_last)
    `ASSERT_IMPLIES(a_load_free, clk, rst_n, load,
        cnt_reg == '0 || (cnt_reg == CNT_W'(1) && take))

endmodule

FILE: test/tb_vlan_tag_insert_strip.sv
// self-checking testbench for vlan_tag_insert_strip: random framed byte streams with
// bursty input, stalling output and a scoreboard fed by a cycle-free tag edit model
// depends on vtis_pkg and the vlan_tag_insert_strip rtl
module tb_vlan_tag_insert_strip;
    import vtis_pkg::*;

    localparam logic MODE_ADD     = 1'b0;
    localparam logic MODE_STRIP   = 1'b1;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   MAX_SHOWN    = 10;
    localparam int   DRAIN_CYCLES = 20;
    localparam int   HOLD_CYCLES  = 80;

    typedef enum int { FR_PLAIN, FR_TAGGED, FR_NEAR_HIGH, FR_NEAR_LOW } frame_kind_t;
    typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_ONES } fill_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // edit model state
    logic [POS_W-1:0] edit_pos    = POS_START;
    byte_t            held_high   = '0;
    logic             edit_tagged = 1'b0;
    logic [11:0]      edit_vid    = '0;
    logic             edit_mode   = MODE_ADD;

    out_item_t edited_q[$];

    int  errors        = 0;
    int  cycles        = 0;
    int  items_sent    = 0;
    int  bytes_checked = 0;
    int  frames_sent   = 0;
    int  tagged_frames = 0;
    int  runts_seen    = 0;
    int  burst_left    = 0;
    bit  no_gaps       = 1'b0;
    bit  hold_req      = 1'b0;
    int  hold_left     = 0;
    int  stall_mode    = 0;
    int  stall_phase   = 0;

    vlan_tag_insert_strip u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected", cycles,
                     edited_q.size());
            $display("tb_vlan_tag_insert_strip: done, errors");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (stall_phase == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_phase = $urandom_range(10, 40);
        end
        else
            stall_phase--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= (cycles % 3 != 0);
            endcase
        end
    end

    task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
        errors++;
        if (errors <= MAX_SHOWN)
            $display({"mismatch (%s) at cycle %0d: expected byte %h last %b runt %b,",
                      " got byte %h last %b runt %b"},
                     what, cycles, want.out_byte, want.out_last, want.runt,
                     got.out_byte, got.out_last, got.runt);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (edited_q.size() == 0)
                note_mismatch("unexpected item", '0, out_data);
            else
            begin
                want = edited_q.pop_front();
                bytes_checked++;
                if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last
                    || out_data.runt !== want.runt)
                    note_mismatch("field", want, out_data);
            end
        end
    end

    task automatic predict_edit(input in_item_t it);
        byte_t     ob [MAX_RESULTS];
        int        n;
        logic      runt_flag;
        out_item_t r;
        n = 0;
        runt_flag = 1'b0;
        if (edit_pos == POS_START)
        begin
            edit_vid    = it.vlan_id;
            edit_mode   = it.mode;
            edit_tagged = 1'b0;
        end
        if (edit_pos < POS_TYPE_HIGH)
            ob[n++] = it.data_byte;
        else if (edit_pos == POS_TYPE_HIGH)
        begin
            held_high = it.data_byte;
            if (it.last_byte)
                ob[n++] = it.data_byte;
        end
        else if (edit_pos == POS_TYPE_LOW)
        begin
            edit_tagged = (held_high == TPID_HIGH) && (it.data_byte == TPID_LOW);
            if (!edit_tagged && edit_mode == MODE_ADD)
            begin
                ob[n++] = TPID_HIGH;
                ob[n++] = TPID_LOW;
                ob[n++] = {4'h0, edit_vid[11:8]};
                ob[n++] = edit_vid[7:0];
            end
            if (!(edit_tagged && edit_mode == MODE_STRIP))
            begin
                ob[n++] = held_high;
                ob[n++] = it.data_byte;
            end
        end
        else if (edit_pos == POS_TAG_HIGH || edit_pos == POS_TAG_LOW)
        begin
            if (!edit_tagged)
                ob[n++] = it.data_byte;
            else if (edit_mode == MODE_ADD)
            begin
                if (edit_pos == POS_TAG_HIGH)
                    ob[n++] = {it.data_byte[7:4], edit_vid[11:8]};
                else
                    ob[n++] = edit_vid[7:0];
            end
        end
        else
            ob[n++] = it.data_byte;

        if (it.last_byte)
        begin
            if (n == 0)
            begin
                ob[n++] = it.data_byte;
                runt_flag = 1'b1;
                runts_seen++;
            end
            edit_pos = POS_START;
        end
        else if (edit_pos < POS_SAT)
            edit_pos = edit_pos + 1'b1;

        for (int i = 0; i < n; i++)
        begin
            r.out_byte = ob[i];
            r.out_last = it.last_byte && (i == n - 1);
            r.runt     = runt_flag;
            edited_q.push_back(r);
        end
    endtask

    task automatic send_item(input in_item_t it);
        if (!no_gaps && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_edit(it);
        if (burst_left > 0)
            burst_left--;
        items_sent++;
    endtask

    task automatic send_frame(input int len, input frame_kind_t kind, input logic strip,
                              input logic [11:0] vid, input fill_t fill);
        in_item_t it;
        byte_t    b;
        frames_sent++;
        if (kind == FR_TAGGED && len >= 14)
            tagged_frames++;
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hff;
                default:   b = byte_t'($urandom);
            endcase
            if (i == 12)
            begin
                if (kind == FR_TAGGED || kind == FR_NEAR_HIGH)
                    b = TPID_HIGH;
                else if (kind == FR_NEAR_LOW && b == TPID_HIGH)
                    b = 8'h88;
            end
            if (i == 13)
            begin
                if (kind == FR_TAGGED || kind == FR_NEAR_LOW)
                    b = TPID_LOW;
                else if (kind == FR_NEAR_HIGH)
                    b = byte_t'($urandom_range(1, 255));
            end
            it.data_byte = b;
            it.last_byte = (i == len - 1);
            it.vlan_id   = (i == 0) ? vid : 12'($urandom);
            it.mode      = (i == 0) ? strip : 1'($urandom);
            send_item(it);
        end
    endtask

    task automatic random_frame(input int min_len);
        int          len;
        int          pick;
        frame_kind_t kind;
        logic [11:0] vid;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            len = $urandom_range(13, 16);
        else if (pick < 7)
            len = $urandom_range(1, 12);
        else
            len = $urandom_range(17, 24);
        if (len < min_len)
            len = min_len;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            kind = FR_TAGGED;
        else if (pick < 8)
            kind = FR_PLAIN;
        else if (pick == 8)
            kind = FR_NEAR_HIGH;
        else
            kind = FR_NEAR_LOW;
        pick = $urandom_range(0, 7);
        vid = (pick == 0) ? 12'h000 : (pick == 1) ? 12'hfff : 12'($urandom);
        send_frame(len, kind, 1'($urandom_range(0, 1)), vid, FILL_RANDOM);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (edited_q.size() != 0);
    endtask

    task automatic test_directed();
        send_frame(1, FR_PLAIN, MODE_STRIP, 12'hfff, FILL_ONES);
        send_frame(14, FR_PLAIN, MODE_ADD, 12'hfff, FILL_ONES);
        send_frame(14, FR_TAGGED, MODE_STRIP, 12'h000, FILL_ZERO);
    endtask

    task automatic test_random_frames();
        while (items_sent < 170)
            random_frame(1);
    endtask

    // receiver holds off while untagged add frames keep coming back to back
    task automatic test_input_backpressure();
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        for (int f = 0; f < 3; f++)
            send_frame($urandom_range(14, 18), FR_PLAIN, MODE_ADD, 12'($urandom), FILL_RANDOM);
        no_gaps = 1'b0;
    endtask

    task automatic test_drain_pause();
        for (int f = 0; f < 2; f++)
        begin
            random_frame(13);
            wait_drained();
        end
        for (int f = 0; f < 2; f++)
            random_frame(13);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_frames();
        test_input_backpressure();
        test_drain_pause();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d bytes in over %0d frames (%0d tagged), %0d bytes out checked, %0d runts",
                 items_sent, frames_sent, tagged_frames, bytes_checked, runts_seen);
        if (errors == 0 && edited_q.size() == 0)
            $display("tb_vlan_tag_insert_strip: done, clean");
        else
            $display("tb_vlan_tag_insert_strip: done, errors");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/vtis_pkg.sv
hw/rtl/vtis_edit.sv
hw/rtl/vlan_tag_insert_strip.sv
test/tb_vlan_tag_insert_strip.sv
